### rtl/lrupin_pkg.sv
// Package for the LRU replacement list with pinning.
// Holds operation codes, status codes, the controller state type and the command bundle.
// Depends on nothing; every other file imports it.
package lrupin_pkg;

   // Operation codes carried on req_operation.
   localparam logic [2:0] OP_TOUCH  = 3'd0;
   localparam logic [2:0] OP_PIN    = 3'd1;
   localparam logic [2:0] OP_UNPIN  = 3'd2;
   localparam logic [2:0] OP_VICTIM = 3'd3;
   localparam logic [2:0] OP_EVICT  = 3'd4;
   localparam logic [2:0] OP_CLEAR  = 3'd5;

   // Status codes returned on rsp_status.
   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_FULL   = 2'd1;
   localparam logic [1:0] STATUS_ABSENT = 2'd2;

   // Controller states.
   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOKUP,
      S_COMMIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic lookup;
      logic commit;
   } cmd_type;

endpackage

### rtl/lrupin_ctrl.sv
// Controller for the LRU replacement list: sequences capture, lookup and commit.
// Also owns the result valid flag. Depends on lrupin_pkg.
module lrupin_ctrl
   import lrupin_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // The output register can take a new result when it is empty or being drained.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Outputs and commands.
   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            cmd.capture = req_valid;
         end
         S_LOOKUP: begin
            cmd.lookup = 1'b1;
         end
         S_COMMIT: begin
            cmd.commit = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // A result stays valid until its transfer completes.
   assign rsp_valid_in = cmd.commit || (rsp_valid_ff && rsp_stall);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### rtl/lrupin_datapath.sv
// Datapath for the LRU replacement list: the row of key cells, match and victim
// vectors, and the result register. Depends on lrupin_pkg.
module lrupin_datapath
   import lrupin_pkg::*;
#(
   parameter  int CAPACITY  = 16,
   parameter  int KEY_WIDTH = 32,
   localparam int CntWidth  = $clog2(CAPACITY + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   input  logic [2:0]           req_operation,
   input  logic [KEY_WIDTH-1:0] req_key,
   output logic [1:0]           rsp_status,
   output logic                 rsp_victim_valid,
   output logic [KEY_WIDTH-1:0] rsp_victim_key,
   output logic [CntWidth-1:0]  rsp_occupancy
);

   // Captured request.
   logic [2:0]           op_ff;
   logic [KEY_WIDTH-1:0] key_ff;

   // Cell row: slot 0 is the most recent entry, occupied slots are packed at the front.
   logic [KEY_WIDTH-1:0] cell_key_ff [CAPACITY];
   logic [KEY_WIDTH-1:0] cell_key_in [CAPACITY];
   logic [CAPACITY-1:0]  cell_valid_ff, cell_valid_in;
   logic [CAPACITY-1:0]  cell_pin_ff, cell_pin_in;
   logic [CntWidth-1:0]  held_ff, held_in;

   // Lookup results.
   logic [CAPACITY-1:0]  hit_ff, hit_in;
   logic [CAPACITY-1:0]  victim_ff, victim_in;

   // Result register.
   logic [1:0]           status_ff, status_in;
   logic                 vvalid_ff, vvalid_in;
   logic [KEY_WIDTH-1:0] vkey_ff, vkey_in;

   // Helpers for the commit step.
   logic                 hit_any;
   logic                 hit_pin;
   logic [CAPACITY-1:0]  upto_hit;
   logic [CAPACITY-1:0]  from_hit;
   logic [KEY_WIDTH-1:0] victim_key_sel;

   // Lookup: match every cell against the key and mark the least recent unpinned cell.
   always_comb begin
      logic later;
      later = 1'b0;
      for (int i = 0; i < CAPACITY; i++) begin
         hit_in[i] = cell_valid_ff[i] && (cell_key_ff[i] == key_ff);
      end
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         victim_in[i] = cell_valid_ff[i] && !cell_pin_ff[i] && !later;
         later        = later || (cell_valid_ff[i] && !cell_pin_ff[i]);
      end
   end

   // Masks around the matching slot and the victim key selection.
   always_comb begin
      logic acc_hi;
      logic acc_lo;
      acc_hi = 1'b0;
      acc_lo = 1'b0;
      victim_key_sel = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         acc_hi      = acc_hi || hit_ff[i];
         upto_hit[i] = acc_hi;
      end
      for (int i = 0; i < CAPACITY; i++) begin
         acc_lo      = acc_lo || hit_ff[i];
         from_hit[i] = acc_lo;
         victim_key_sel = victim_key_sel | (cell_key_ff[i] & {KEY_WIDTH{victim_ff[i]}});
      end
      hit_any = |hit_ff;
      hit_pin = |(hit_ff & cell_pin_ff);
   end

   // Commit: next cell contents and the result of the operation.
   always_comb begin
      cell_key_in   = cell_key_ff;
      cell_valid_in = cell_valid_ff;
      cell_pin_in   = cell_pin_ff;
      held_in       = held_ff;
      status_in     = STATUS_OK;
      vvalid_in     = 1'b0;
      vkey_in       = '0;
      case (op_ff) inside
         OP_TOUCH: begin
            if (hit_any || (held_ff < CntWidth'(CAPACITY))) begin
               // Slots ahead of the match (or the whole row on insert) move back by one.
               for (int i = 1; i < CAPACITY; i++) begin
                  if (!hit_any || upto_hit[i]) begin
                     cell_key_in[i]   = cell_key_ff[i-1];
                     cell_valid_in[i] = cell_valid_ff[i-1];
                     cell_pin_in[i]   = cell_pin_ff[i-1];
                  end
               end
               cell_key_in[0]   = key_ff;
               cell_valid_in[0] = 1'b1;
               cell_pin_in[0]   = hit_any && hit_pin;
               if (!hit_any) begin
                  held_in = held_ff + CntWidth'(1);
               end
            end else begin
               status_in = STATUS_FULL;
            end
         end
         OP_PIN, OP_UNPIN: begin
            if (hit_any) begin
               if (op_ff == OP_PIN) begin
                  cell_pin_in = cell_pin_ff | hit_ff;
               end else begin
                  cell_pin_in = cell_pin_ff & ~hit_ff;
               end
            end else begin
               status_in = STATUS_ABSENT;
            end
         end
         OP_VICTIM: begin
            vvalid_in = |victim_ff;
            vkey_in   = victim_key_sel;
         end
         OP_EVICT: begin
            if (hit_any) begin
               // Slots from the match onward move forward to close the gap.
               for (int i = 0; i < CAPACITY - 1; i++) begin
                  if (from_hit[i]) begin
                     cell_key_in[i]   = cell_key_ff[i+1];
                     cell_valid_in[i] = cell_valid_ff[i+1];
                     cell_pin_in[i]   = cell_pin_ff[i+1];
                  end
               end
               cell_valid_in[CAPACITY-1] = 1'b0;
               cell_pin_in[CAPACITY-1]   = 1'b0;
               held_in = held_ff - CntWidth'(1);
            end else begin
               status_in = STATUS_ABSENT;
            end
         end
         OP_CLEAR: begin
            cell_valid_in = '0;
            cell_pin_in   = '0;
            held_in       = '0;
         end
         default: begin
            status_in = STATUS_OK;
         end
      endcase
   end

   // Request capture, lookup vectors, cell keys and result payload.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_operation;
         key_ff <= req_key;
      end
      if (cmd.lookup) begin
         hit_ff    <= hit_in;
         victim_ff <= victim_in;
      end
      if (cmd.commit) begin
         cell_key_ff <= cell_key_in;
         status_ff   <= status_in;
         vvalid_ff   <= vvalid_in;
         vkey_ff     <= vkey_in;
      end
   end

   // Occupancy and flags of the cell row.
   always_ff @(posedge clock) begin
      if (reset) begin
         cell_valid_ff <= '0;
         cell_pin_ff   <= '0;
         held_ff       <= '0;
      end else if (cmd.commit) begin
         cell_valid_ff <= cell_valid_in;
         cell_pin_ff   <= cell_pin_in;
         held_ff       <= held_in;
      end
   end

   assign rsp_status       = status_ff;
   assign rsp_victim_valid = vvalid_ff;
   assign rsp_victim_key   = vkey_ff;
   assign rsp_occupancy    = held_ff;

endmodule

### rtl/lru_replacement_with_pinning_core.sv
// LRU replacement list with pinning: recency-ordered key cells with pin flags.
// A result is registered after its request transfer passes the lookup and commit steps over the
// cell row; commit waits while a stalled result holds the output register. No request is taken
// until commit is done; one is taken while an earlier result still waits in the output register.
// Reset (synchronous, active high) empties the list, clears all pins and drops any pending result.
// Depends on lrupin_pkg, lrupin_ctrl and lrupin_datapath.
module lru_replacement_with_pinning_core
   import lrupin_pkg::*;
#(
   parameter int CAPACITY  = 16,
   parameter int KEY_WIDTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [2:0]                         req_operation,
   input  logic [KEY_WIDTH-1:0]               req_key,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [1:0]                         rsp_status,
   output logic                               rsp_victim_valid,
   output logic [KEY_WIDTH-1:0]               rsp_victim_key,
   output logic [$clog2(CAPACITY + 1)-1:0]    rsp_occupancy
);

   cmd_type cmd;

   // Sequencer for each transfer.
   lrupin_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // Cell row and result register.
   lrupin_datapath #(
      .CAPACITY  (CAPACITY),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_operation    (req_operation),
      .req_key          (req_key),
      .rsp_status       (rsp_status),
      .rsp_victim_valid (rsp_victim_valid),
      .rsp_victim_key   (rsp_victim_key),
      .rsp_occupancy    (rsp_occupancy)
   );

endmodule

### tb/tb_lru_replacement_with_pinning_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for the LRU replacement list with pinning.
// It depends on lrupin_pkg for the operation and status codes, and on the core RTL.
// A clocked driver and monitor exchange transfers with random idle and stall gaps.
module tb_lru_replacement_with_pinning_core;
   import lrupin_pkg::*;

   localparam int LIST_DEPTH     = 16;
   localparam int KEY_BITS       = 32;
   localparam int OCC_BITS       = $clog2(LIST_DEPTH + 1);
   localparam int TOTAL_ITEMS    = 1950;
   localparam int SETTLE_CYCLES  = 20;
   localparam int WATCHDOG_LIMIT = 4000;

   // Operation codes that the block does not define; they must leave the list alone.
   localparam logic [2:0] OP_SPARE6 = 3'd6;
   localparam logic [2:0] OP_SPARE7 = 3'd7;

   typedef struct {
      bit                  wait_drain;
      logic [2:0]          op;
      logic [KEY_BITS-1:0] key;
   } list_op_type;

   typedef struct packed {
      logic [1:0]          status;
      logic                victim_valid;
      logic [KEY_BITS-1:0] victim_key;
      logic [OCC_BITS-1:0] occupancy;
   } list_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [2:0]          req_operation = OP_TOUCH;
   logic [KEY_BITS-1:0] req_key = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [1:0]          rsp_status;
   logic                rsp_victim_valid;
   logic [KEY_BITS-1:0] rsp_victim_key;
   logic [OCC_BITS-1:0] rsp_occupancy;

   // Shadow copy of the recency list; slot 0 is the most recently used key.
   logic [KEY_BITS-1:0] slot_key [LIST_DEPTH];
   logic                slot_valid [LIST_DEPTH];
   logic                slot_pin [LIST_DEPTH];
   int                  held_count;

   list_op_type         op_queue[$];
   list_result_type     due_results[$];
   int                  ops_accepted = 0;
   int                  results_taken = 0;
   int                  mismatch_count = 0;
   int                  send_gap = 0;
   int                  send_calm = 0;
   int                  stall_left = 0;
   int                  stall_calm = 0;
   int                  quiet_cycles = 0;
   int                  op_tally [8] = '{default: 0};
   int                  refused_inserts = 0;
   int                  absent_keys = 0;
   int                  empty_victims = 0;

   lru_replacement_with_pinning_core #(
      .CAPACITY  (LIST_DEPTH),
      .KEY_WIDTH (KEY_BITS)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_key          (req_key),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_victim_valid (rsp_victim_valid),
      .rsp_victim_key   (rsp_victim_key),
      .rsp_occupancy    (rsp_occupancy)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      $display("%0t ns: MISMATCH %s", $time, what);
      mismatch_count++;
   endtask

   // Idle lengths are mostly short, sometimes long, with occasional runs of no idling.
   function automatic int draw_idle(inout int calm);
      int roll;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         calm = $urandom_range(20, 80);
         return 0;
      end
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic wipe_list();
      for (int i = 0; i < LIST_DEPTH; i++) begin
         slot_key[i]   = '0;
         slot_valid[i] = 1'b0;
         slot_pin[i]   = 1'b0;
      end
      held_count = 0;
   endtask

   // Moves the entry at slot pos to the front and shifts the newer entries back.
   task automatic promote_slot(input int pos);
      logic [KEY_BITS-1:0] k;
      logic                pn;
      k  = slot_key[pos];
      pn = slot_pin[pos];
      for (int i = pos; i > 0; i--) begin
         slot_key[i]   = slot_key[i - 1];
         slot_valid[i] = slot_valid[i - 1];
         slot_pin[i]   = slot_pin[i - 1];
      end
      slot_key[0]   = k;
      slot_valid[0] = 1'b1;
      slot_pin[0]   = pn;
   endtask

   // Applies one operation to the shadow list and queues the result it must produce.
   task automatic apply_list_op(input logic [2:0] op, input logic [KEY_BITS-1:0] k);
      list_result_type r;
      int              hit;
      r   = '0;
      hit = -1;
      for (int i = 0; i < LIST_DEPTH; i++)
         if (slot_valid[i] && slot_key[i] == k) hit = i;
      case (op)
         OP_TOUCH: begin
            if (hit >= 0) begin
               promote_slot(hit);
            end else if (held_count < LIST_DEPTH) begin
               // The last slot is free: the new key starts there unpinned.
               slot_key[LIST_DEPTH - 1]   = k;
               slot_valid[LIST_DEPTH - 1] = 1'b1;
               slot_pin[LIST_DEPTH - 1]   = 1'b0;
               promote_slot(LIST_DEPTH - 1);
               held_count++;
            end else begin
               r.status = STATUS_FULL;
               refused_inserts++;
            end
         end
         OP_PIN, OP_UNPIN: begin
            if (hit >= 0) begin
               slot_pin[hit] = (op == OP_PIN);
            end else begin
               r.status = STATUS_ABSENT;
               absent_keys++;
            end
         end
         OP_VICTIM: begin
            for (int i = LIST_DEPTH - 1; i >= 0; i--)
               if (slot_valid[i] && !slot_pin[i] && !r.victim_valid) begin
                  r.victim_valid = 1'b1;
                  r.victim_key   = slot_key[i];
               end
            if (!r.victim_valid) empty_victims++;
         end
         OP_EVICT: begin
            if (hit >= 0) begin
               for (int i = hit; i < LIST_DEPTH - 1; i++) begin
                  slot_key[i]   = slot_key[i + 1];
                  slot_valid[i] = slot_valid[i + 1];
                  slot_pin[i]   = slot_pin[i + 1];
               end
               slot_key[LIST_DEPTH - 1]   = '0;
               slot_valid[LIST_DEPTH - 1] = 1'b0;
               slot_pin[LIST_DEPTH - 1]   = 1'b0;
               held_count--;
            end else begin
               r.status = STATUS_ABSENT;
               absent_keys++;
            end
         end
         OP_CLEAR: wipe_list();
         default: ;
      endcase
      r.occupancy = OCC_BITS'(held_count);
      op_tally[op]++;
      due_results.push_back(r);
   endtask

   task automatic queue_op(input logic [2:0] op, input logic [KEY_BITS-1:0] k);
      list_op_type item;
      item.wait_drain = 1'b0;
      item.op         = op;
      item.key        = k;
      op_queue.push_back(item);
   endtask

   // A hold-off marker: the driver sends nothing until every result is back.
   task automatic queue_drain();
      list_op_type item;
      item.wait_drain = 1'b1;
      item.op         = OP_TOUCH;
      item.key        = '0;
      op_queue.push_back(item);
   endtask

   // Keys lean toward the extremes and single-bit patterns, the rest fully random.
   function automatic logic [KEY_BITS-1:0] fresh_key();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 5) return '0;
      if (roll < 10) return '1;
      if (roll < 20) return KEY_BITS'(1) << $urandom_range(0, KEY_BITS - 1);
      if (roll < 30) return ~(KEY_BITS'(1) << $urandom_range(0, KEY_BITS - 1));
      return $urandom;
   endfunction

   // Driver: presents queued operations and updates the shadow list on each transfer.
   always @(posedge clock) begin
      list_op_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         wipe_list();
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            apply_list_op(req_operation, req_key);
            ops_accepted++;
         end
         if (!(req_valid && req_stall)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (op_queue.size() == 0) begin
               req_valid <= 1'b0;
            end else if (op_queue[0].wait_drain) begin
               req_valid <= 1'b0;
               if (ops_accepted == results_taken) void'(op_queue.pop_front());
            end else begin
               nxt = op_queue.pop_front();
               req_valid     <= 1'b1;
               req_operation <= nxt.op;
               req_key       <= nxt.key;
               send_gap = draw_idle(send_calm);
            end
         end
      end
   end

   // Monitor: checks each result transfer against the oldest outstanding expectation.
   always @(posedge clock) begin
      list_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_taken <= results_taken + 1;
            if (due_results.size() == 0) begin
               report_mismatch($sformatf("result with none outstanding, occupancy %0d",
                                         rsp_occupancy));
            end else begin
               want = due_results.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_status, want.status));
               if (rsp_victim_valid !== want.victim_valid)
                  report_mismatch($sformatf("victim_valid %0b, expected %0b",
                                            rsp_victim_valid, want.victim_valid));
               if (rsp_victim_key !== want.victim_key)
                  report_mismatch($sformatf("victim_key 0x%0h, expected 0x%0h",
                                            rsp_victim_key, want.victim_key));
               if (rsp_occupancy !== want.occupancy)
                  report_mismatch($sformatf("occupancy %0d, expected %0d",
                                            rsp_occupancy, want.occupancy));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            stall_left = draw_idle(stall_calm);
         end
      end
   end

   // Watchdog: ends the run when no transfer happens for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [KEY_BITS-1:0] pool [24];
      int                  pool_size;
      int                  run_len;
      int                  roll;
      int                  queued;
      logic [2:0]          op;
      logic [KEY_BITS-1:0] k;

      // Directed: empty list, absent keys, a full list and its refusal, pinned victims.
      queue_op(OP_VICTIM, '1);
      queue_op(OP_PIN, 32'h1234_5678);
      queue_op(OP_UNPIN, 32'h1234_5678);
      queue_op(OP_EVICT, 32'h1234_5678);
      queue_op(OP_TOUCH, '0);
      queue_op(OP_TOUCH, '1);
      for (int i = 0; i < LIST_DEPTH - 2; i++) queue_op(OP_TOUCH, KEY_BITS'(1) << i);
      queue_op(OP_TOUCH, 32'hA5A5_5A5A);
      queue_op(OP_TOUCH, '0);
      queue_op(OP_PIN, '1);
      queue_op(OP_VICTIM, '0);
      queue_op(OP_EVICT, '1);
      queue_op(OP_TOUCH, 32'hA5A5_5A5A);
      queue_op(OP_SPARE6, $urandom);
      queue_op(OP_SPARE7, $urandom);
      queue_op(OP_CLEAR, '1);
      queue_op(OP_VICTIM, '0);
      queue_drain();
      queued = op_queue.size() - 1;

      // Random phases: each works a small key pool so that hits, pins and overflow recur.
      while (queued < TOTAL_ITEMS) begin
         roll = $urandom_range(0, 9);
         if (roll < 6) pool_size = $urandom_range(2, 8);
         else if (roll < 9) pool_size = $urandom_range(9, 16);
         else pool_size = $urandom_range(17, 24);
         for (int i = 0; i < pool_size; i++) pool[i] = fresh_key();
         run_len = $urandom_range(20, 90);
         for (int n = 0; n < run_len; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 40) op = OP_TOUCH;
            else if (roll < 52) op = OP_PIN;
            else if (roll < 62) op = OP_UNPIN;
            else if (roll < 80) op = OP_VICTIM;
            else if (roll < 94) op = OP_EVICT;
            else if (roll < 96) op = OP_CLEAR;
            else if (roll < 98) op = OP_SPARE6;
            else op = OP_SPARE7;
            if ($urandom_range(0, 9) == 0) k = $urandom;
            else k = pool[$urandom_range(0, pool_size - 1)];
            queue_op(op, k);
            queued++;
         end
         roll = $urandom_range(0, 5);
         if (roll == 0) begin
            queue_drain();
         end else if (roll == 1) begin
            queue_op(OP_CLEAR, $urandom);
            queued++;
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (op_queue.size() != 0 || req_valid || ops_accepted != results_taken);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Ran %0d list operations: touch %0d, pin %0d, unpin %0d, victim %0d, evict %0d,",
               ops_accepted, op_tally[OP_TOUCH], op_tally[OP_PIN], op_tally[OP_UNPIN],
               op_tally[OP_VICTIM], op_tally[OP_EVICT]);
      $display("clear %0d, unused codes %0d; %0d refused inserts, %0d absent keys, %0d %s",
               op_tally[OP_CLEAR], op_tally[OP_SPARE6] + op_tally[OP_SPARE7],
               refused_inserts, absent_keys, empty_victims, "empty victims.");
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
